// File: src/slh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slh_pkg
// Shared codes, result record and lookup functions for the session link
// handshake block.
// ----------------------------------------------------------------------------
package slh_pkg;

   // Packet codes L010..L080
   localparam logic [2:0] PKT_L010 = 3'd0;
   localparam logic [2:0] PKT_L020 = 3'd1;
   localparam logic [2:0] PKT_L030 = 3'd2;
   localparam logic [2:0] PKT_L040 = 3'd3;
   localparam logic [2:0] PKT_L050 = 3'd4;
   localparam logic [2:0] PKT_L060 = 3'd5;
   localparam logic [2:0] PKT_L070 = 3'd6;
   localparam logic [2:0] PKT_L080 = 3'd7;

   // Event kinds
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_PACKET  = 1'b1;

   // Status classes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_READY = 2'd1;
   localparam logic [1:0] STS_TIME_ERR  = 2'd2;
   localparam logic [1:0] STS_OTHER     = 2'd3;

   // Session state codes as shown on the result port
   localparam logic [2:0] LS_IDLE        = 3'd0;
   localparam logic [2:0] LS_WAIT_LINK   = 3'd1;
   localparam logic [2:0] LS_TIME_EARLY  = 3'd2;
   localparam logic [2:0] LS_WAIT_LOGIN  = 3'd3;
   localparam logic [2:0] LS_WAIT_SUBSYS = 3'd4;
   localparam logic [2:0] LS_READY       = 3'd5;
   localparam logic [2:0] LS_SIGNOUT     = 3'd6;
   localparam logic [2:0] LS_ERROR       = 3'd7;

   // Trade kinds
   localparam logic [2:0] TK_NONE    = 3'd0;
   localparam logic [2:0] TK_REGULAR = 3'd1;
   localparam logic [2:0] TK_FIX     = 3'd2;
   localparam logic [2:0] TK_ODD     = 3'd3;
   localparam logic [2:0] TK_AUCTION = 3'd4;
   localparam logic [2:0] TK_LEND    = 3'd5;
   localparam logic [2:0] TK_TENDER  = 3'd6;

   // Configuration register indexes
   localparam logic [1:0] CSR_MARKET     = 2'd0;
   localparam logic [1:0] CSR_SUB_SYSTEM = 2'd1;

   // Worker key groups
   localparam logic [1:0] GRP_LINK   = 2'd0;
   localparam logic [1:0] GRP_LOGIN  = 2'd1;
   localparam logic [1:0] GRP_SIGNOF = 2'd2;

   typedef struct packed {
      logic        send_valid;
      logic [2:0]  send_code;
      logic [13:0] worker_key;
      logic [2:0]  link_state;
      logic [2:0]  trade_kind_out;
      logic        timer_start;
      logic        clear_registration;
      logic        subsys_ready;
      logic        error_seen;
   } result_type;

   function automatic logic [13:0] key_for(input logic market, input logic [1:0] group);
      logic [13:0] key;
      case (group)
         GRP_LINK:  key = market ? 14'd9110 : 14'd1010;
         GRP_LOGIN: key = market ? 14'd9120 : 14'd1020;
         default:   key = market ? 14'd9130 : 14'd1030;
      endcase
      return key;
   endfunction

   function automatic logic [2:0] decode_kind(input logic [6:0] code);
      logic [2:0] tk;
      case (code)
         7'd30, 7'd93: tk = TK_REGULAR;
         7'd32, 7'd98: tk = TK_FIX;
         7'd40, 7'd94: tk = TK_ODD;
         7'd70:        tk = TK_AUCTION;
         7'd31, 7'd90: tk = TK_LEND;
         7'd41, 7'd97: tk = TK_TENDER;
         default:      tk = TK_NONE;
      endcase
      return tk;
   endfunction

endpackage

// File: src/slh_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slh_fsm
// Session state and trade kind registers with the one-step decision that
// turns an accepted event into its result record.
// ----------------------------------------------------------------------------
module slh_fsm
   import slh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       kind,
   input  logic [2:0] packet_code,
   input  logic [1:0] status_class,
   input  logic       market,
   input  logic [6:0] sub_system,
   output result_type res
);

   typedef enum logic [2:0] {
      ST_IDLE        = 3'd0,
      ST_WAIT_LINK   = 3'd1,
      ST_TIME_EARLY  = 3'd2,
      ST_WAIT_LOGIN  = 3'd3,
      ST_WAIT_SUBSYS = 3'd4,
      ST_READY       = 3'd5,
      ST_SIGNOUT     = 3'd6,
      ST_ERROR       = 3'd7
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] trade_kind_ff, trade_kind_in;
   result_type r;

   always_comb begin
      r             = '0;
      state_in      = state_ff;
      trade_kind_in = trade_kind_ff;
      if (kind == KIND_RESTART) begin
         r.send_valid  = 1'b1;
         r.send_code   = PKT_L010;
         r.worker_key  = key_for(market, GRP_LINK);
         r.timer_start = 1'b1;
         state_in      = ST_WAIT_LINK;
      end else begin
         case (packet_code)
            PKT_L010: begin
               r.timer_start = 1'b1;
               if (status_class == STS_OK) begin
                  r.clear_registration = 1'b1;
                  r.send_valid         = 1'b1;
                  r.send_code          = PKT_L020;
                  r.worker_key         = key_for(market, GRP_LINK);
                  state_in             = ST_WAIT_LINK;
               end else if (status_class == STS_NOT_READY) begin
                  state_in = ST_TIME_EARLY;
               end else begin
                  // time error raises error_seen; both classes go into wait link
                  r.error_seen = (status_class == STS_TIME_ERR);
                  state_in     = ST_WAIT_LINK;
               end
            end
            PKT_L020: begin
               r.timer_start = 1'b1;
               state_in      = ST_WAIT_LINK;
            end
            PKT_L030: begin
               if ((state_ff != ST_WAIT_LINK) || (status_class == STS_OK)) begin
                  r.send_valid  = 1'b1;
                  r.timer_start = 1'b1;
                  if (state_ff != ST_WAIT_LINK) begin
                     r.send_code  = PKT_L010;
                     r.worker_key = key_for(market, GRP_LINK);
                     state_in     = ST_WAIT_LINK;
                  end else begin
                     r.send_code  = PKT_L040;
                     r.worker_key = key_for(market, GRP_LOGIN);
                     state_in     = ST_WAIT_LOGIN;
                  end
               end else begin
                  r.error_seen = 1'b1;
                  state_in     = ST_ERROR;
               end
            end
            PKT_L040: begin
               r.timer_start = 1'b1;
               state_in      = ST_WAIT_LOGIN;
            end
            PKT_L050: begin
               r.send_valid = 1'b1;
               if ((state_ff == ST_WAIT_LOGIN) && (status_class == STS_OK)) begin
                  r.send_code    = PKT_L060;
                  r.worker_key   = key_for(market, GRP_LOGIN);
                  r.subsys_ready = 1'b1;
                  trade_kind_in  = decode_kind(sub_system);
                  state_in       = ST_WAIT_SUBSYS;
               end else begin
                  // wrong state or failed login: restart the link
                  r.error_seen  = (state_ff == ST_WAIT_LOGIN);
                  r.send_code   = PKT_L010;
                  r.worker_key  = key_for(market, GRP_LINK);
                  r.timer_start = 1'b1;
                  state_in      = ST_WAIT_LINK;
               end
            end
            PKT_L060: begin
               r.timer_start = 1'b1;
               state_in      = ST_READY;
            end
            PKT_L070: begin
               r.send_valid = 1'b1;
               if (status_class == STS_OK) begin
                  r.send_code  = PKT_L080;
                  r.worker_key = key_for(market, GRP_SIGNOF);
                  state_in     = ST_SIGNOUT;
               end else begin
                  r.error_seen  = 1'b1;
                  r.send_code   = PKT_L010;
                  r.worker_key  = key_for(market, GRP_LINK);
                  r.timer_start = 1'b1;
                  state_in      = ST_WAIT_LINK;
               end
            end
            default: begin
               state_in = ST_SIGNOUT;
            end
         endcase
      end
      r.link_state     = state_in;
      r.trade_kind_out = trade_kind_in;
   end

   assign res = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         trade_kind_ff <= TK_NONE;
      end else if (accept) begin
         state_ff      <= state_in;
         trade_kind_ff <= trade_kind_in;
      end
   end

endmodule

// File: src/session_link_handshake_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_link_handshake_fsm
// Link and login handshake of an exchange session: one event in, one
// result out, with session state and trade kind kept between events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req_    | in        | valid / stall      | kind, packet_code, status_class
//  rsp_    | out       | valid / stall      | send_*, worker_key, link_state,
//          |           |                    | trade_kind_out, pulses, error
//  csr_    | in        | valid / ready      | index, data (market, sub_system)
//
//  One item per cycle while req_stall is low; a result is registered in the
//  result register, or parked in the skid entry while the output is held.
//  The decision is a single pass of logic from the request ports and the
//  state registers into the result register. Reset is synchronous and
//  clears session state, trade kind, the configuration registers and the
//  valid flags of both result stages. A two-entry output (result register
//  plus skid) keeps taking items while one result waits; req_stall rises
//  only when the skid entry is full. csr_ready is always high; write configuration only while idle.
// ----------------------------------------------------------------------------
module session_link_handshake_fsm
   import slh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [2:0]  req_packet_code,
   input  logic [1:0]  req_status_class,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_valid,
   output logic [2:0]  rsp_send_code,
   output logic [13:0] rsp_worker_key,
   output logic [2:0]  rsp_link_state,
   output logic [2:0]  rsp_trade_kind_out,
   output logic        rsp_timer_start,
   output logic        rsp_clear_registration,
   output logic        rsp_subsys_ready,
   output logic        rsp_error_seen,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   logic       market_ff;
   logic [6:0] sub_system_ff;

   logic       accept;
   logic       out_load;
   result_type res;

   result_type rsp_ff;
   logic       rsp_valid_ff;
   result_type skid_ff;
   logic       skid_valid_ff;

   // Configuration: always ready, latch on handshake
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         market_ff     <= 1'b0;
         sub_system_ff <= 7'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MARKET:     market_ff     <= csr_data[0];
            CSR_SUB_SYSTEM: sub_system_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   // Hold off new items only while the skid entry is occupied
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   slh_fsm u_fsm (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_kind),
      .packet_code  (req_packet_code),
      .status_class (req_status_class),
      .market       (market_ff),
      .sub_system   (sub_system_ff),
      .res          (res)
   );

   // Result register advances when empty or taken downstream
   assign out_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         if (skid_valid_ff) begin
            // drain the skid entry first; no item is taken this cycle
            rsp_ff        <= skid_ff;
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
            if (accept) begin
               rsp_ff <= res;
            end
         end
      end else if (accept) begin
         // output held: park the new result
         skid_ff       <= res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_send_valid         = rsp_ff.send_valid;
   assign rsp_send_code          = rsp_ff.send_code;
   assign rsp_worker_key         = rsp_ff.worker_key;
   assign rsp_link_state         = rsp_ff.link_state;
   assign rsp_trade_kind_out     = rsp_ff.trade_kind_out;
   assign rsp_timer_start        = rsp_ff.timer_start;
   assign rsp_clear_registration = rsp_ff.clear_registration;
   assign rsp_subsys_ready       = rsp_ff.subsys_ready;
   assign rsp_error_seen         = rsp_ff.error_seen;

endmodule

// File: src/slh_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slh_chk
// Port-level checks for the session link handshake block, bound to the
// top level.
// ----------------------------------------------------------------------------
module slh_chk
   import slh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_send_valid,
   input logic [2:0]  rsp_send_code,
   input logic [13:0] rsp_worker_key,
   input logic [2:0]  rsp_link_state,
   input logic        rsp_timer_start,
   input logic        rsp_subsys_ready,
   input logic        rsp_error_seen
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_link_state)
         && $stable(rsp_send_code) && $stable(rsp_worker_key))
      else $error("stalled result changed");

   // no request means zero code and key
   a_no_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_valid |-> rsp_send_code == PKT_L010 && rsp_worker_key == 14'd0)
      else $error("code or key set without a request");

   // subsystem ready only with L060 request in wait subsys
   a_subsys: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_subsys_ready |->
         rsp_link_state == LS_WAIT_SUBSYS && rsp_send_code == PKT_L060 && rsp_send_valid)
      else $error("subsystem ready outside login completion");

   // an error either rearms the timer or parks in error
   a_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_seen |-> rsp_timer_start || rsp_link_state == LS_ERROR)
      else $error("error without restart or error state");

endmodule

bind session_link_handshake_fsm slh_chk u_slh_chk (.*);

// File: tb/session_link_handshake_fsm_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// session_link_handshake_fsm_test
// Self-checking bench for the session link handshake block. A behavioral
// session tracker predicts every result from the items the block takes.
// A checker compares each result with the oldest prediction, field by field.
// Traffic is a directed login walk, then directed failure and wrong-state
// cases, then random sessions under several market and subsystem settings.
// Sender bursts and receiver stalls are random throughout.
// ----------------------------------------------------------------------------
module session_link_handshake_fsm_test;
   import slh_pkg::*;

   // Stop the run after this many cycles in which no channel moves anything.
   localparam int unsigned IDLE_LIMIT = 2000;
   // Target number of random items, spread over the random phases.
   localparam int unsigned RANDOM_ITEMS = 740;
   localparam int unsigned RANDOM_PHASES = 8;

   // ------------------------------------------------------------------------
   // Clock, reset and block ports. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_RESTART;
   logic [2:0]  req_packet_code = PKT_L010;
   logic [1:0]  req_status_class = STS_OK;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_valid;
   logic [2:0]  rsp_send_code;
   logic [13:0] rsp_worker_key;
   logic [2:0]  rsp_link_state;
   logic [2:0]  rsp_trade_kind_out;
   logic        rsp_timer_start;
   logic        rsp_clear_registration;
   logic        rsp_subsys_ready;
   logic        rsp_error_seen;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MARKET;
   logic [6:0]  csr_data = 7'd0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   session_link_handshake_fsm DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_packet_code        (req_packet_code),
      .req_status_class       (req_status_class),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_send_valid         (rsp_send_valid),
      .rsp_send_code          (rsp_send_code),
      .rsp_worker_key         (rsp_worker_key),
      .rsp_link_state         (rsp_link_state),
      .rsp_trade_kind_out     (rsp_trade_kind_out),
      .rsp_timer_start        (rsp_timer_start),
      .rsp_clear_registration (rsp_clear_registration),
      .rsp_subsys_ready       (rsp_subsys_ready),
      .rsp_error_seen         (rsp_error_seen),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   // ------------------------------------------------------------------------
   // Session tracker: its own copy of the configuration and session state.
   // ------------------------------------------------------------------------
   logic        market_cfg = 1'b0;
   logic [6:0]  subsys_cfg = 7'd0;
   logic [2:0]  session_now = LS_IDLE;
   logic [2:0]  trade_now = TK_NONE;

   // Results predicted for items already taken, oldest first.
   result_type  replies_due[$];

   // Subsystem codes that map to a trade kind; anything else maps to none.
   logic [6:0]  known_subsys [0:10] = '{7'd30, 7'd31, 7'd32, 7'd40, 7'd41, 7'd70,
                                         7'd90, 7'd93, 7'd94, 7'd97, 7'd98};

   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_cycle = 0;
   int unsigned stall_mode = 0;
   result_type  want;

   // Keys step by ten through the link, login and signoff groups.
   function automatic logic [13:0] worker_key_for(input logic [1:0] grp);
      logic [13:0] base;
      base = market_cfg ? 14'd9110 : 14'd1010;
      return base + 14'd10 * 14'(grp);
   endfunction

   function automatic logic [2:0] trade_kind_for(input logic [6:0] code);
      logic [2:0] tk;
      tk = TK_NONE;
      case (code)
         7'd30, 7'd93: tk = TK_REGULAR;
         7'd32, 7'd98: tk = TK_FIX;
         7'd40, 7'd94: tk = TK_ODD;
         7'd70:        tk = TK_AUCTION;
         7'd31, 7'd90: tk = TK_LEND;
         7'd41, 7'd97: tk = TK_TENDER;
         default:      tk = TK_NONE;
      endcase
      return tk;
   endfunction

   // Advance the session by one item and return the result it must produce.
   function automatic result_type handshake_step(input logic kind, input logic [2:0] pkt,
                                                 input logic [1:0] sts);
      result_type r;
      logic       relink;
      logic       issue;
      logic [2:0] issue_code;
      logic [1:0] issue_grp;
      r = '0;
      relink = 1'b0;
      issue = 1'b0;
      issue_code = PKT_L010;
      issue_grp = GRP_LINK;
      if (kind == KIND_RESTART) begin
         relink = 1'b1;
      end else begin
         case (pkt)
            PKT_L010: begin
               // Link reply: success asks for L020; a time error raises error_seen
               // and the session lands back in wait link.
               r.timer_start = 1'b1;
               if (sts == STS_OK) begin
                  r.clear_registration = 1'b1;
                  issue = 1'b1;
                  issue_code = PKT_L020;
                  issue_grp = GRP_LINK;
                  session_now = LS_WAIT_LINK;
               end else if (sts == STS_NOT_READY) begin
                  session_now = LS_TIME_EARLY;
               end else begin
                  if (sts == STS_TIME_ERR) r.error_seen = 1'b1;
                  session_now = LS_WAIT_LINK;
               end
            end
            PKT_L020: begin
               session_now = LS_WAIT_LINK;
               r.timer_start = 1'b1;
            end
            PKT_L030: begin
               if (session_now != LS_WAIT_LINK) begin
                  relink = 1'b1;
               end else if (sts == STS_OK) begin
                  issue = 1'b1;
                  issue_code = PKT_L040;
                  issue_grp = GRP_LOGIN;
                  session_now = LS_WAIT_LOGIN;
                  r.timer_start = 1'b1;
               end else begin
                  session_now = LS_ERROR;
                  r.error_seen = 1'b1;
               end
            end
            PKT_L040: begin
               session_now = LS_WAIT_LOGIN;
               r.timer_start = 1'b1;
            end
            PKT_L050: begin
               if (session_now != LS_WAIT_LOGIN) begin
                  relink = 1'b1;
               end else if (sts == STS_OK) begin
                  issue = 1'b1;
                  issue_code = PKT_L060;
                  issue_grp = GRP_LOGIN;
                  session_now = LS_WAIT_SUBSYS;
                  trade_now = trade_kind_for(subsys_cfg);
                  r.subsys_ready = 1'b1;
               end else begin
                  r.error_seen = 1'b1;
                  relink = 1'b1;
               end
            end
            PKT_L060: begin
               session_now = LS_READY;
               r.timer_start = 1'b1;
            end
            PKT_L070: begin
               if (sts == STS_OK) begin
                  issue = 1'b1;
                  issue_code = PKT_L080;
                  issue_grp = GRP_SIGNOF;
                  session_now = LS_SIGNOUT;
               end else begin
                  r.error_seen = 1'b1;
                  relink = 1'b1;
               end
            end
            default: session_now = LS_SIGNOUT;
         endcase
      end
      // Restart the link: send L010 on the link key and rearm the timer.
      if (relink) begin
         issue = 1'b1;
         issue_code = PKT_L010;
         issue_grp = GRP_LINK;
         session_now = LS_WAIT_LINK;
         r.timer_start = 1'b1;
      end
      if (issue) begin
         r.send_valid = 1'b1;
         r.send_code = issue_code;
         r.worker_key = worker_key_for(issue_grp);
      end
      r.link_state = session_now;
      r.trade_kind_out = trade_now;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Monitors. All of them sample at the rising edge, before the block's
   // registers move, so they see exactly what the block sees.
   // ------------------------------------------------------------------------

   // Track configuration writes and predict a result for each item taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MARKET) market_cfg = csr_data[0];
            else if (csr_index == CSR_SUB_SYSTEM) subsys_cfg = csr_data;
         end
         if (req_valid && !req_stall)
            replies_due.push_back(handshake_step(req_kind, req_packet_code, req_status_class));
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned wanted);
      $display("ERROR @%0t: %s got %0d wanted %0d", $time, what, got, wanted);
      mismatch_count++;
   endtask

   // Compare every result the block hands over with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            report_mismatch("result with nothing pending, link_state",
                            32'(rsp_link_state), 32'd0);
         end else begin
            want = replies_due.pop_front();
            if (rsp_send_valid !== want.send_valid)
               report_mismatch("send_valid", 32'(rsp_send_valid), 32'(want.send_valid));
            if (rsp_send_code !== want.send_code)
               report_mismatch("send_code", 32'(rsp_send_code), 32'(want.send_code));
            if (rsp_worker_key !== want.worker_key)
               report_mismatch("worker_key", 32'(rsp_worker_key), 32'(want.worker_key));
            if (rsp_link_state !== want.link_state)
               report_mismatch("link_state", 32'(rsp_link_state), 32'(want.link_state));
            if (rsp_trade_kind_out !== want.trade_kind_out)
               report_mismatch("trade_kind_out", 32'(rsp_trade_kind_out),
                               32'(want.trade_kind_out));
            if (rsp_timer_start !== want.timer_start)
               report_mismatch("timer_start", 32'(rsp_timer_start), 32'(want.timer_start));
            if (rsp_clear_registration !== want.clear_registration)
               report_mismatch("clear_registration", 32'(rsp_clear_registration),
                               32'(want.clear_registration));
            if (rsp_subsys_ready !== want.subsys_ready)
               report_mismatch("subsys_ready", 32'(rsp_subsys_ready),
                               32'(want.subsys_ready));
            if (rsp_error_seen !== want.error_seen)
               report_mismatch("error_seen", 32'(rsp_error_seen), 32'(want.error_seen));
         end
      end
   end

   // Receiver back-pressure: the mode is redrawn periodically among no stall,
   // light and heavy random stall, and a fixed three-of-five pattern.
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_cycle % 5) < 3);
      endcase
   end

   // Watchdog: give up when no channel has moved anything for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Present one item and hold it until the block takes it. Between bursts,
   // drop valid for a random gap. Valid stays high after the handshake so a
   // following item goes out back to back; callers that stop sending must
   // lower it in the same step.
   task automatic send_item(input logic kind, input logic [2:0] code, input logic [1:0] sts);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_packet_code <= code;
      req_status_class <= sts;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_noise_item();
      send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                2'($urandom_range(0, 3)));
   endtask

   // Stop sending and hold until every predicted result has come back, then
   // let the result register settle.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_due.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write one register, only while the block is idle.
   task automatic write_csr(input logic [1:0] index, input logic [6:0] value);
      wait_for_replies();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic mkt, input logic [6:0] subsys);
      write_csr(CSR_MARKET, {6'd0, mkt});
      write_csr(CSR_SUB_SYSTEM, subsys);
   endtask

   // One login session in order L010..L080 with mostly good status. Now and
   // then inject a stray item or break the session off early.
   task automatic run_session();
      int unsigned step_i;
      logic [1:0]  sts;
      send_item(KIND_RESTART, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      for (step_i = 0; step_i < 8; step_i++) begin
         if ($urandom_range(0, 19) == 0) break;
         if ($urandom_range(0, 9) == 0) send_noise_item();
         sts = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : STS_OK;
         send_item(KIND_PACKET, step_i[2:0], sts);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Walk a clean login and signout on the listed market keys.
   task automatic test_login_flow();
      set_config(1'b0, 7'd30);
      send_item(KIND_RESTART, PKT_L010, STS_OK);
      send_item(KIND_PACKET, PKT_L010, STS_OK);
      send_item(KIND_PACKET, PKT_L020, STS_OK);
      send_item(KIND_PACKET, PKT_L030, STS_OK);
      send_item(KIND_PACKET, PKT_L040, STS_OK);
      send_item(KIND_PACKET, PKT_L050, STS_OK);
      send_item(KIND_PACKET, PKT_L060, STS_OK);
      send_item(KIND_PACKET, PKT_L070, STS_OK);
      send_item(KIND_PACKET, PKT_L080, STS_OK);
   endtask

   // Failure and wrong-state paths on the other market with the unknown
   // subsystem code 99.
   task automatic test_error_paths();
      set_config(1'b1, 7'd99);
      // restart with every payload bit set
      send_item(KIND_RESTART, 3'd7, 2'd3);
      // early link, then time error falling through to wait link
      send_item(KIND_PACKET, PKT_L010, STS_NOT_READY);
      send_item(KIND_PACKET, PKT_L010, STS_TIME_ERR);
      send_item(KIND_PACKET, PKT_L010, STS_OTHER);
      // L030 failure in wait link enters the error state
      send_item(KIND_PACKET, PKT_L030, STS_TIME_ERR);
      // L030 and L050 out of turn restart the link
      send_item(KIND_PACKET, PKT_L030, STS_OK);
      send_item(KIND_PACKET, PKT_L050, STS_OK);
      // L050 failure during login restarts the link
      send_item(KIND_PACKET, PKT_L040, STS_OK);
      send_item(KIND_PACKET, PKT_L050, STS_OTHER);
      // L050 success with an unknown subsystem sets trade kind to none
      send_item(KIND_PACKET, PKT_L040, STS_NOT_READY);
      send_item(KIND_PACKET, PKT_L050, STS_OK);
      // L070 failure in wait subsys restarts the link; L080 then enters signout
      send_item(KIND_PACKET, PKT_L070, STS_NOT_READY);
      send_item(KIND_PACKET, PKT_L080, STS_OTHER);
   endtask

   // Random sessions under changing settings; the first two phases pin market 0
   // with subsystem 0 and market 1 with subsystem 99, the rest draw from known and unknown codes.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned phase_end;
      logic        mkt;
      logic [6:0]  subsys;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            mkt = 1'b0;
            subsys = 7'd0;
         end else if (phase == 1) begin
            mkt = 1'b1;
            subsys = 7'd99;
         end else begin
            mkt = 1'($urandom_range(0, 1));
            subsys = ($urandom_range(0, 9) < 7) ? known_subsys[4'($urandom_range(0, 10))]
                                                : 7'($urandom_range(0, 99));
         end
         set_config(mkt, subsys);
         phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 6) == 0) send_noise_item();
            else run_session();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_login_flow();
      test_error_paths();
      test_random_traffic();
      wait_for_replies();
      repeat (4) @(posedge clock);
      if (replies_due.size() != 0)
         report_mismatch("results still pending", 32'(replies_due.size()), 32'd0);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
src/slh_pkg.sv
src/slh_fsm.sv
src/session_link_handshake_fsm.sv
src/slh_chk.sv
tb/session_link_handshake_fsm_test.sv
